>>> rtl/core/brat_pkg.sv
// Shared types and constants of the best rational approximation block.
`default_nettype none
package brat_pkg;

   localparam int unsigned CSR_DATA_W          = 32;
   localparam int unsigned CSR_EB_W            = 32;
   localparam int unsigned CNT_W               = 8;
   localparam int unsigned CSR_DENOM_LIMIT_RST = 1048575;

   localparam logic CSR_DENOM_LIMIT = 1'b0;
   localparam logic CSR_ERROR_BOUND = 1'b1;

   // datapath operations
   localparam logic [3:0] OP_NONE = 4'd0;
   localparam logic [3:0] OP_INIT = 4'd1;
   localparam logic [3:0] OP_P    = 4'd2;
   localparam logic [3:0] OP_Q    = 4'd3;
   localparam logic [3:0] OP_DIV  = 4'd4;
   localparam logic [3:0] OP_DML  = 4'd5;
   localparam logic [3:0] OP_DMR  = 4'd6;
   localparam logic [3:0] OP_K    = 4'd7;
   localparam logic [3:0] OP_NML  = 4'd8;
   localparam logic [3:0] OP_NMR  = 4'd9;
   localparam logic [3:0] OP_LHS  = 4'd10;
   localparam logic [3:0] OP_UPD  = 4'd11;
   localparam logic [3:0] OP_PDR  = 4'd12;
   localparam logic [3:0] OP_QDL  = 4'd13;
   localparam logic [3:0] OP_ERR  = 4'd14;
   localparam logic [3:0] OP_NEXT = 4'd15;

   localparam logic [1:0] SIDE_0 = 2'd0;
   localparam logic [1:0] SIDE_L = 2'd1;
   localparam logic [1:0] SIDE_R = 2'd2;

   typedef struct packed {
      logic [3:0] op;
      logic       go;
      logic       load;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic t_zero;
      logic side_zero;
      logic dm_gt;
      logic hit;
      logic stop;
   } sts_type;

endpackage
`default_nettype wire

>>> rtl/core/brat_mul.sv
// Serial shift-add multiplier, one bit of the narrow operand per cycle.
`default_nettype none
module brat_mul #(
   parameter int AW = 52,
   parameter int BW = 21
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [AW-1:0]      a,
   input  wire logic [BW-1:0]      b,
   output logic                    done,
   output logic [AW+BW-1:0]        product
);
   localparam int PW  = AW + BW;
   localparam int CNW = $clog2(BW + 1);

   logic [PW-1:0]  acc_ff;
   logic [PW-1:0]  a_sh_ff;
   logic [BW-1:0]  b_sh_ff;
   logic [CNW-1:0] cnt_ff;
   logic           busy_ff;
   logic           done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == CNW'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNW'(BW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNW'(1);
            if (cnt_ff == CNW'(1)) busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff  <= '0;
         a_sh_ff <= PW'(a);
         b_sh_ff <= b;
      end else if (busy_ff) begin
         if (b_sh_ff[0]) acc_ff <= acc_ff + a_sh_ff;
         a_sh_ff <= a_sh_ff << 1;
         b_sh_ff <= b_sh_ff >> 1;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule
`default_nettype wire

>>> rtl/core/brat_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module brat_div #(
   parameter int WIDTH = 52
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] dividend,
   input  wire logic [WIDTH-1:0] divisor,
   output logic                  done,
   output logic [WIDTH-1:0]      quotient
);
   localparam int CNW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] rem_ff;
   logic [WIDTH-1:0] quo_ff;
   logic [WIDTH-1:0] dvs_ff;
   logic [CNW-1:0]   cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   diff;
   logic             ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[WIDTH-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = shifted >= {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == CNW'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNW'(WIDTH);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNW'(1);
            if (cnt_ff == CNW'(1)) busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
         quo_ff <= {quo_ff[WIDTH-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

>>> rtl/core/brat_dp.sv
// Datapath: search registers, config registers, shared multiplier and divider.
`default_nettype none
module brat_dp #(
   parameter int FRAC_BITS  = 32,
   parameter int DENOM_BITS = 20
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire brat_pkg::cmd_type             cmd,
   output brat_pkg::sts_type                  sts,
   input  wire logic                          csr_we,
   input  wire logic                          csr_index,
   input  wire logic [brat_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic [FRAC_BITS-1:0]          req_target_fraction,
   output logic [DENOM_BITS-1:0]              rsp_numerator,
   output logic [DENOM_BITS-1:0]              rsp_denominator,
   output logic signed [FRAC_BITS:0]          rsp_signed_error,
   output logic [brat_pkg::CNT_W-1:0]         rsp_iteration_count
);
   import brat_pkg::*;

   localparam int F   = FRAC_BITS;
   localparam int D   = DENOM_BITS;
   localparam int W   = F + D;
   localparam int BW  = D + 1;
   localparam int PW  = W + BW;
   localparam int DMW = 2 * D + 1;
   localparam int CW  = (F + 1 > CSR_EB_W) ? F + 1 : CSR_EB_W;

   logic [D-1:0]        denom_limit_ff;
   logic [CSR_EB_W-1:0] error_bound_ff;
   logic [F-1:0]        t_ff;
   logic [D-1:0]        lmax_ff, cur_ff;
   logic [D-1:0]        nl_ff, dl_ff, nr_ff, dr_ff;
   logic [W-1:0]        p_ff, q_ff;
   logic [BW-1:0]       bl_ff, br_ff;
   logic [1:0]          side_ff;
   logic [DMW-1:0]      dm_ff;
   logic [D-1:0]        nm_ff;
   logic [W-1:0]        lhs_ff;
   logic [PW-1:0]       x_ff;
   logic [D-1:0]        n_ff, d_ff;
   logic [F:0]          e_ff;
   logic [CNT_W-1:0]    total_ff;
   logic [3:0]          pend_ff;
   logic                done_ff;
   logic [D-1:0]        on_ff, od_ff;
   logic [F:0]          oe_ff;
   logic [CNT_W-1:0]    ot_ff;

   logic          is_mul, is_div, mul_go, div_go, mul_done, div_done;
   logic [W-1:0]  mul_a;
   logic [BW-1:0] mul_b;
   logic [PW-1:0] mprod;
   logic [W-1:0]  div_n, div_d, dquot;
   logic [W-1:0]  rhs;
   logic [BW-1:0] sat_q, kval;
   logic [D-1:0]  lim_ld;
   logic [D+3:0]  c10;
   logic [F:0]    mag;
   logic [CW-1:0] mag_x, eb_x;

   always_comb begin
      is_mul = 1'b0;
      is_div = 1'b0;
      mul_a  = '0;
      mul_b  = '0;
      div_n  = '0;
      div_d  = '0;
      case (cmd.op)
         OP_P:   begin is_mul = 1'b1; mul_a = W'(t_ff);  mul_b = BW'(dl_ff); end
         OP_Q:   begin is_mul = 1'b1; mul_a = W'(t_ff);  mul_b = BW'(dr_ff); end
         OP_DML: begin is_mul = 1'b1; mul_a = W'(dl_ff); mul_b = bl_ff; end
         OP_DMR: begin is_mul = 1'b1; mul_a = W'(dr_ff); mul_b = br_ff; end
         OP_NML: begin is_mul = 1'b1; mul_a = W'(nl_ff); mul_b = bl_ff; end
         OP_NMR: begin is_mul = 1'b1; mul_a = W'(nr_ff); mul_b = br_ff; end
         OP_LHS: begin is_mul = 1'b1; mul_a = W'(t_ff);  mul_b = BW'(dm_ff[D-1:0]); end
         OP_PDR: begin is_mul = 1'b1; mul_a = p_ff;      mul_b = BW'(dr_ff); end
         OP_QDL: begin is_mul = 1'b1; mul_a = q_ff;      mul_b = BW'(dl_ff); end
         OP_DIV: begin
            is_div = 1'b1;
            div_n  = (p_ff > q_ff) ? p_ff : q_ff;
            div_d  = (p_ff > q_ff) ? q_ff : p_ff;
         end
         OP_K: begin
            is_div = 1'b1;
            if (side_ff == SIDE_L) begin
               div_n = W'(cur_ff - dl_ff);
               div_d = W'(dr_ff);
            end else begin
               div_n = W'(cur_ff - dr_ff);
               div_d = W'(dl_ff);
            end
         end
         OP_ERR: begin
            is_div = 1'b1;
            div_n  = {n_ff, {F{1'b0}}};
            div_d  = W'(d_ff);
         end
         default: ;
      endcase
   end

   assign mul_go = cmd.go && is_mul;
   assign div_go = cmd.go && is_div;

   brat_mul #(.AW(W), .BW(BW)) u_mul (
      .clock(clock), .reset(reset), .start(mul_go), .a(mul_a), .b(mul_b),
      .done(mul_done), .product(mprod)
   );

   brat_div #(.WIDTH(W)) u_div (
      .clock(clock), .reset(reset), .start(div_go), .dividend(div_n), .divisor(div_d),
      .done(div_done), .quotient(dquot)
   );

   always_comb begin
      rhs    = {nm_ff, {F{1'b0}}};
      sat_q  = (|dquot[W-1:D]) ? {1'b1, {D{1'b0}}} : {1'b0, dquot[D-1:0]};
      kval   = (dquot[D-1:0] == '0) ? BW'(1) : {1'b0, dquot[D-1:0]};
      lim_ld = (denom_limit_ff == '0) ? D'(1) : denom_limit_ff;
      c10    = ({4'b0, cur_ff} << 3) + ({4'b0, cur_ff} << 1);
      mag    = e_ff[F] ? (~e_ff + (F+1)'(1)) : e_ff;
      mag_x  = CW'(mag);
      eb_x   = CW'(error_bound_ff);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         denom_limit_ff <= D'(CSR_DENOM_LIMIT_RST);
         error_bound_ff <= '0;
         done_ff        <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_DENOM_LIMIT) denom_limit_ff <= csr_wdata[D-1:0];
            else error_bound_ff <= csr_wdata[CSR_EB_W-1:0];
         end
         done_ff <= (cmd.go && !is_mul && !is_div) || mul_done || div_done;
      end
   end

   // search registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         t_ff     <= req_target_fraction;
         lmax_ff  <= lim_ld;
         cur_ff   <= (error_bound_ff == '0) ? lim_ld : D'(1);
         total_ff <= '0;
      end
      if (cmd.go) begin
         pend_ff <= cmd.op;
         case (cmd.op)
            OP_INIT: begin
               nl_ff <= '0;     dl_ff <= D'(1);
               nr_ff <= D'(1);  dr_ff <= D'(1);
               n_ff  <= '0;     d_ff  <= D'(1);
            end
            OP_DIV: begin
               if (total_ff != '1) total_ff <= total_ff + CNT_W'(1);
               if (p_ff > q_ff)      side_ff <= SIDE_L;
               else if (p_ff < q_ff) side_ff <= SIDE_R;
               else                  side_ff <= SIDE_0;
            end
            OP_UPD: begin
               if (lhs_ff == rhs) begin
                  n_ff <= nm_ff;
                  d_ff <= dm_ff[D-1:0];
               end else if (lhs_ff < rhs) begin
                  nr_ff <= nm_ff;
                  dr_ff <= dm_ff[D-1:0];
               end else begin
                  nl_ff <= nm_ff;
                  dl_ff <= dm_ff[D-1:0];
               end
            end
            OP_NEXT: cur_ff <= (c10 > (D+4)'(lmax_ff)) ? lmax_ff : c10[D-1:0];
            default: ;
         endcase
      end
      if (mul_done) begin
         case (pend_ff)
            OP_P:   p_ff   <= mprod[W-1:0] - {nl_ff, {F{1'b0}}};
            OP_Q:   q_ff   <= {nr_ff, {F{1'b0}}} - mprod[W-1:0];
            OP_DML: dm_ff  <= mprod[DMW-1:0];
            OP_DMR: dm_ff  <= dm_ff + mprod[DMW-1:0];
            OP_NML: nm_ff  <= mprod[D-1:0];
            OP_NMR: nm_ff  <= nm_ff + mprod[D-1:0];
            OP_LHS: lhs_ff <= mprod[W-1:0];
            OP_PDR: x_ff   <= mprod;
            OP_QDL: begin
               // tie goes to the left end point
               if (x_ff <= mprod) begin
                  n_ff <= nl_ff; d_ff <= dl_ff;
               end else begin
                  n_ff <= nr_ff; d_ff <= dr_ff;
               end
            end
            default: ;
         endcase
      end
      if (div_done) begin
         case (pend_ff)
            OP_DIV: begin
               if (side_ff == SIDE_L) begin
                  bl_ff <= BW'(1); br_ff <= sat_q;
               end else if (side_ff == SIDE_R) begin
                  bl_ff <= sat_q;  br_ff <= BW'(1);
               end else begin
                  bl_ff <= BW'(1); br_ff <= BW'(1);
               end
            end
            OP_K: begin
               if (side_ff == SIDE_L) br_ff <= kval;
               else bl_ff <= kval;
            end
            OP_ERR: e_ff <= {1'b0, t_ff} - dquot[F:0];
            default: ;
         endcase
      end
      if (cmd.emit) begin
         on_ff <= n_ff;
         od_ff <= d_ff;
         oe_ff <= e_ff;
         ot_ff <= total_ff;
      end
   end

   always_comb begin
      sts.done      = done_ff;
      sts.t_zero    = (t_ff == '0);
      sts.side_zero = (side_ff == SIDE_0);
      sts.dm_gt     = dm_ff > DMW'(cur_ff);
      sts.hit       = (lhs_ff == rhs);
      sts.stop      = (mag_x <= eb_x) || (cur_ff >= lmax_ff);
   end

   assign rsp_numerator       = on_ff;
   assign rsp_denominator     = od_ff;
   assign rsp_signed_error    = $signed(oe_ff);
   assign rsp_iteration_count = ot_ff;
endmodule
`default_nettype wire

>>> rtl/core/brat_ctrl.sv
// Controller: sequences the search operations and owns both handshakes.
`default_nettype none
module brat_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output brat_pkg::cmd_type      cmd,
   input  wire brat_pkg::sts_type sts
);
   import brat_pkg::*;

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_INIT = 5'd1;
   localparam logic [4:0] ST_P    = 5'd2;
   localparam logic [4:0] ST_Q    = 5'd3;
   localparam logic [4:0] ST_DIV  = 5'd4;
   localparam logic [4:0] ST_DML  = 5'd5;
   localparam logic [4:0] ST_DMR  = 5'd6;
   localparam logic [4:0] ST_K    = 5'd7;
   localparam logic [4:0] ST_DML2 = 5'd8;
   localparam logic [4:0] ST_DMR2 = 5'd9;
   localparam logic [4:0] ST_NML  = 5'd10;
   localparam logic [4:0] ST_NMR  = 5'd11;
   localparam logic [4:0] ST_LHS  = 5'd12;
   localparam logic [4:0] ST_UPD  = 5'd13;
   localparam logic [4:0] ST_FP   = 5'd14;
   localparam logic [4:0] ST_FQ   = 5'd15;
   localparam logic [4:0] ST_PDR  = 5'd16;
   localparam logic [4:0] ST_QDL  = 5'd17;
   localparam logic [4:0] ST_ERR  = 5'd18;
   localparam logic [4:0] ST_CHK  = 5'd19;
   localparam logic [4:0] ST_NEXT = 5'd20;
   localparam logic [4:0] ST_DONE = 5'd21;

   logic [4:0] state_ff, state_in;
   logic       issued_ff, issued_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [3:0] op;
   logic       emit;

   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      emit     = 1'b0;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_INIT;
         ST_INIT: begin
            op = OP_INIT;
            if (sts.done) state_in = sts.t_zero ? ST_ERR : ST_P;
         end
         ST_P:   begin op = OP_P;   if (sts.done) state_in = ST_Q;   end
         ST_Q:   begin op = OP_Q;   if (sts.done) state_in = ST_DIV; end
         ST_DIV: begin op = OP_DIV; if (sts.done) state_in = ST_DML; end
         ST_DML: begin op = OP_DML; if (sts.done) state_in = ST_DMR; end
         ST_DMR: begin
            op = OP_DMR;
            if (sts.done) begin
               if (!sts.dm_gt)        state_in = ST_NML;
               else if (sts.side_zero) state_in = ST_FP;
               else                    state_in = ST_K;
            end
         end
         ST_K:    begin op = OP_K;   if (sts.done) state_in = ST_DML2; end
         ST_DML2: begin op = OP_DML; if (sts.done) state_in = ST_DMR2; end
         ST_DMR2: begin
            // still over the limit after clamping: stop on the end points
            op = OP_DMR;
            if (sts.done) state_in = sts.dm_gt ? ST_FP : ST_NML;
         end
         ST_NML: begin op = OP_NML; if (sts.done) state_in = ST_NMR; end
         ST_NMR: begin op = OP_NMR; if (sts.done) state_in = ST_LHS; end
         ST_LHS: begin op = OP_LHS; if (sts.done) state_in = ST_UPD; end
         ST_UPD: begin
            op = OP_UPD;
            if (sts.done) state_in = sts.hit ? ST_ERR : ST_P;
         end
         ST_FP:   begin op = OP_P;   if (sts.done) state_in = ST_FQ;  end
         ST_FQ:   begin op = OP_Q;   if (sts.done) state_in = ST_PDR; end
         ST_PDR:  begin op = OP_PDR; if (sts.done) state_in = ST_QDL; end
         ST_QDL:  begin op = OP_QDL; if (sts.done) state_in = ST_ERR; end
         ST_ERR:  begin op = OP_ERR; if (sts.done) state_in = ST_CHK; end
         ST_CHK:  state_in = sts.stop ? ST_DONE : ST_NEXT;
         ST_NEXT: begin op = OP_NEXT; if (sts.done) state_in = ST_INIT; end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op   = op;
      cmd.go   = (op != OP_NONE) && !issued_ff;
      cmd.load = (state_ff == ST_IDLE) && req_valid;
      cmd.emit = emit;
      issued_in    = sts.done ? 1'b0 : (issued_ff || cmd.go);
      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

>>> rtl/core/best_rational_approximation.sv
// Top level of the best rational approximation block.
//
// Usage: an item on req_ (target_fraction, a fraction of 2^FRAC_BITS) is taken
// when req_valid and req_ready are high; one result (numerator, denominator,
// signed_error, iteration_count) leaves on rsp_ per item, valid/ready.
// csr_we writes register csr_index (0 denominator limit, 1 error_bound) from
// csr_wdata. The user writes only while no item is in flight; the block itself
// has no guard for this.
// Operation: one item at a time. Each multiply op runs on the serial
// multiplier and each division op on the restoring divider. A plain mediant
// step is seven multiplies, one division and an update; a step that clamps
// adds a division and two multiplies. A search costs its steps plus the
// closing compare and error division, and with error_bound set the searches
// for limits 1, 10, 100 and on up to the denominator limit add up.
// The result sits in an output register, so the next item is taken while the
// previous result waits; a stalled receiver holds the block only once a
// second result is ready to be written.
// Reset (synchronous, active high) empties the block and sets the denominator
// limit to its full value and error_bound to zero.
`default_nettype none
module best_rational_approximation #(
   parameter int FRAC_BITS  = 32,
   parameter int DENOM_BITS = 20
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [FRAC_BITS-1:0]            req_target_fraction,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [DENOM_BITS-1:0]                rsp_numerator,
   output logic [DENOM_BITS-1:0]                rsp_denominator,
   output logic signed [FRAC_BITS:0]            rsp_signed_error,
   output logic [brat_pkg::CNT_W-1:0]           rsp_iteration_count,
   input  wire logic                            csr_we,
   input  wire logic                            csr_index,
   input  wire logic [brat_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import brat_pkg::*;

   cmd_type cmd;
   sts_type sts;

   brat_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .cmd(cmd), .sts(sts)
   );

   brat_dp #(.FRAC_BITS(FRAC_BITS), .DENOM_BITS(DENOM_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_target_fraction(req_target_fraction),
      .rsp_numerator(rsp_numerator), .rsp_denominator(rsp_denominator),
      .rsp_signed_error(rsp_signed_error), .rsp_iteration_count(rsp_iteration_count)
   );

`ifndef SYNTHESIS
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid) else $error("result not presented after emit");
   a_go_done: assert property (@(posedge clock) disable iff (reset)
      !(cmd.go && sts.done)) else $error("operation issued while one completes");
   a_denom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_denominator != '0 && rsp_numerator <= rsp_denominator))
      else $error("result fraction out of range");
`endif
endmodule
`default_nettype wire

>>> test/best_rational_approximation_tb.sv
// Self-checking testbench for the best rational approximation block.
`default_nettype none
module best_rational_approximation_tb;
   import brat_pkg::*;

   typedef struct {
      logic [19:0] numer;
      logic [19:0] denom;
      logic [32:0] err;
      logic [7:0]  steps;
   } approx_type;

   // one row of the directed table: a register write or an item
   typedef struct {
      bit          is_write;
      logic        index;
      logic [31:0] wdata;
      logic [31:0] target;
      bit          typed;
      approx_type  want;
   } row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [31:0] req_target_fraction = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [19:0] rsp_numerator;
   logic [19:0] rsp_denominator;
   logic signed [32:0] rsp_signed_error;
   logic [7:0]  rsp_iteration_count;
   logic        csr_we = 0;
   logic        csr_index = CSR_DENOM_LIMIT;
   logic [31:0] csr_wdata = '0;

   logic [19:0] model_denom_limit;
   logic [31:0] model_bound;
   approx_type  pending[$];
   bit          failed = 0;
   bit          no_idle = 0;
   int          rsp_hold = 0;

   best_rational_approximation DUT (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // Farey search with skipping multipliers for one limit
   function automatic void farey_search(input logic [63:0] t, input logic [63:0] lim,
                                        output logic [63:0] n, output logic [63:0] d,
                                        output int steps);
      logic [63:0] nl, dl, nr, dr, p, q, bl, br, dm, nm, k;
      logic [127:0] lp, rq;
      int side;
      nl = 0; dl = 1; nr = 1; dr = 1;
      steps = 0;
      if (t == 0) begin
         n = 0; d = 1;
         return;
      end
      while (dl <= lim && dr <= lim) begin
         steps++;
         side = 0;
         p = t * dl - (nl << 32);
         q = (nr << 32) - t * dr;
         br = p / q;
         bl = q / p;
         if (bl == 0) begin bl = 1; side = -1; end
         if (br == 0) begin br = 1; side = 1; end
         if (bl > 64'h1_0000_0000) bl = 64'h1_0000_0000;
         if (br > 64'h1_0000_0000) br = 64'h1_0000_0000;
         dm = dl * bl + dr * br;
         if (dm > lim) begin
            if (side == -1) begin
               k = (lim - dl) / dr;
               br = (k != 0) ? k : 1;
            end else if (side == 1) begin
               k = (lim - dr) / dl;
               bl = (k != 0) ? k : 1;
            end
         end
         dm = dl * bl + dr * br;
         if (dm > lim) break;
         nm = nl * bl + nr * br;
         if (t * dm == (nm << 32)) begin
            n = nm; d = dm;
            return;
         end
         if (t * dm < (nm << 32)) begin nr = nm; dr = dm; end
         else begin nl = nm; dl = dm; end
      end
      p = t * dl - (nl << 32);
      q = (nr << 32) - t * dr;
      lp = 128'(p) * 128'(dr);
      rq = 128'(q) * 128'(dl);
      if (lp <= rq) begin n = nl; d = dl; end
      else begin n = nr; d = dr; end
   endfunction

   function automatic approx_type best_approx(input logic [31:0] target);
      logic [63:0] t, lim, cur, n, d, mag;
      logic signed [63:0] e;
      int steps, total;
      approx_type r;
      t = 64'(target);
      lim = (model_denom_limit != 0) ? 64'(model_denom_limit) : 64'd1;
      cur = (model_bound == 0) ? lim : 64'd1;
      farey_search(t, cur, n, d, steps);
      total = steps;
      e = $signed(t) - $signed((n << 32) / d);
      if (model_bound != 0) begin
         forever begin
            mag = (e < 0) ? -e : e;
            if (mag <= 64'(model_bound) || cur >= lim) break;
            cur = cur * 10;
            if (cur > lim) cur = lim;
            farey_search(t, cur, n, d, steps);
            total += steps;
            e = $signed(t) - $signed((n << 32) / d);
         end
      end
      if (total > 255) total = 255;
      r.numer = n[19:0];
      r.denom = d[19:0];
      r.err = e[32:0];
      r.steps = total[7:0];
      return r;
   endfunction

   task automatic csr_write(input logic index, input logic [31:0] value);
      // stop offering the last item again while the block drains
      req_valid <= 0;
      while (pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we <= 1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
      if (index == CSR_DENOM_LIMIT) model_denom_limit = value[19:0];
      else model_bound = value;
   endtask

   task automatic send_item(input logic [31:0] target, input bit typed, input approx_type want);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_target_fraction <= target;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending.push_back(typed ? want : best_approx(target));
   endtask

   function automatic logic [31:0] rand_target();
      int unsigned d;
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return $urandom_range(0, 255);
         2: return ~32'($urandom_range(0, 255));
         default: begin
            // fraction of a small denominator, truncated to 32 bits
            d = $urandom_range(2, 2000);
            return 32'((64'($urandom_range(1, d - 1)) << 32) / d);
         end
      endcase
   endfunction

   // result side: compare and stall
   always @(posedge clock) begin
      approx_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending.size() == 0) begin
            $error("result with no item outstanding");
            failed = 1;
         end else begin
            exp_r = pending.pop_front();
            if (rsp_numerator !== exp_r.numer) begin
               $error("numerator: expected %0d, got %0d", exp_r.numer, rsp_numerator);
               failed = 1;
            end
            if (rsp_denominator !== exp_r.denom) begin
               $error("denominator: expected %0d, got %0d", exp_r.denom, rsp_denominator);
               failed = 1;
            end
            if (rsp_signed_error !== exp_r.err) begin
               $error("signed_error: expected %0d, got %0d",
                      $signed(exp_r.err), rsp_signed_error);
               failed = 1;
            end
            if (rsp_iteration_count !== exp_r.steps) begin
               $error("iteration_count: expected %0d, got %0d",
                      exp_r.steps, rsp_iteration_count);
               failed = 1;
            end
         end
         rsp_hold = no_idle ? 0 : $urandom_range(0, 4);
      end
      rsp_ready <= !reset && rsp_hold == 0;
      if (rsp_hold > 0) rsp_hold--;
   end

   initial begin
      row_type plan[$];
      approx_type z;
      z = '{numer: 0, denom: 1, err: 0, steps: 0};
      // after reset: zero target, one half, extremes and other fractions
      plan.push_back('{0, 0, 0, 32'h0, 1, z});
      plan.push_back('{0, 0, 0, 32'h8000_0000, 1, '{1, 2, 0, 1}});
      plan.push_back('{0, 0, 0, 32'hFFFF_FFFF, 0, z});
      plan.push_back('{0, 0, 0, 32'h0000_0001, 0, z});
      plan.push_back('{0, 0, 0, 32'h5555_5555, 0, z});
      plan.push_back('{0, 0, 0, 32'hAAAA_AAAA, 0, z});
      plan.push_back('{0, 0, 0, 32'h243F_6A88, 0, z});
      // limit of one: the first mediant is already over the limit, tie goes left
      plan.push_back('{1, CSR_DENOM_LIMIT, 32'd1, 0, 0, z});
      plan.push_back('{0, 0, 0, 32'h8000_0000, 1, '{0, 1, 33'h0_8000_0000, 1}});
      plan.push_back('{0, 0, 0, 32'hFFFF_FFFF, 0, z});
      plan.push_back('{0, 0, 0, 32'h0, 1, z});
      // upper bits dropped: limit field reads zero, treated as one
      plan.push_back('{1, CSR_DENOM_LIMIT, 32'hFFF0_0000, 0, 0, z});
      plan.push_back('{0, 0, 0, 32'h4000_0000, 0, z});
      plan.push_back('{0, 0, 0, 32'hC000_0001, 0, z});
      // small limit, clamped multipliers
      plan.push_back('{1, CSR_DENOM_LIMIT, 32'd7, 0, 0, z});
      plan.push_back('{0, 0, 0, 32'h0000_0100, 0, z});
      plan.push_back('{0, 0, 0, 32'hFFFF_FF00, 0, z});
      // stepped limit search
      plan.push_back('{1, CSR_DENOM_LIMIT, 32'hF_FFFF, 0, 0, z});
      plan.push_back('{1, CSR_ERROR_BOUND, 32'd1000, 0, 0, z});
      plan.push_back('{0, 0, 0, 32'h243F_6A88, 0, z});
      plan.push_back('{0, 0, 0, 32'h0000_0001, 0, z});
      plan.push_back('{1, CSR_ERROR_BOUND, 32'hFFFF_FFFF, 0, 0, z});
      plan.push_back('{0, 0, 0, 32'h9E37_79B9, 0, z});
      plan.push_back('{1, CSR_ERROR_BOUND, 32'd1, 0, 0, z});
      plan.push_back('{0, 0, 0, 32'h6A09_E667, 0, z});

      model_denom_limit = 20'hF_FFFF;
      model_bound = 0;
      repeat (2) @(posedge clock);
      reset <= 0;

      foreach (plan[i]) begin
         if (plan[i].is_write) csr_write(plan[i].index, plan[i].wdata);
         else send_item(plan[i].target, plan[i].typed, plan[i].want);
      end

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               csr_write(CSR_DENOM_LIMIT, 32'hF_FFFF);
               csr_write(CSR_ERROR_BOUND, 0);
            end
            1: csr_write(CSR_DENOM_LIMIT, $urandom_range(1, 1000));
            2: begin
               csr_write(CSR_DENOM_LIMIT, 32'hF_FFFF);
               csr_write(CSR_ERROR_BOUND, $urandom_range(1, 1 << 20));
            end
            3: begin
               csr_write(CSR_DENOM_LIMIT, $urandom_range(1, 200));
               csr_write(CSR_ERROR_BOUND, $urandom());
            end
            4: begin
               csr_write(CSR_DENOM_LIMIT, $urandom_range(1, 20'hF_FFFF));
               csr_write(CSR_ERROR_BOUND, 0);
            end
            default: csr_write(CSR_DENOM_LIMIT, $urandom());
         endcase
         no_idle = (ph == 4);
         for (int k = 0; k < 20; k++) send_item(rand_target(), 0, z);
      end
      no_idle = 0;
      @(posedge clock);
      req_valid <= 0;
      while (pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (!failed) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   initial begin
      #1_000_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
`default_nettype wire
